// ----- sv/fpms_pkg.sv -----
`default_nettype none

package fpms_pkg;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned LENGTH_W    = 5;
  localparam int unsigned OFFSET_W    = 32;
  localparam int unsigned MATCH_POS_W = 32;
  // bytes held by the two 64-bit pattern registers
  localparam int unsigned PATTERN_REG_BYTES = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PATTERN_LOW    = 2'd0,
    CFG_PATTERN_HIGH   = 2'd1,
    CFG_PATTERN_LENGTH = 2'd2,
    CFG_START_OFFSET   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } text_item_t;

  typedef struct packed {
    logic                   found;
    logic [MATCH_POS_W-1:0] match_position;
  } result_item_t;

endpackage

`default_nettype wire

// ----- sv/first_pattern_match_search.sv -----
// first_pattern_match_search
//
// Text bytes enter on the text channel (text_valid / text_stall / text_item),
// one per cycle unless stalled. Each accepted byte is shifted into a window of
// the PATTERN_MAX newest bytes, and the window is compared lane by lane with
// the configured pattern in the same cycle. The first match that begins at or
// after start_offset produces one result with found = 1 and the start
// position; later bytes of that text give nothing. If the text ends without a
// match, the byte flagged last_byte produces one result with found = 0.
// A result enters the result queue when its byte is accepted and is offered from the queue head.
// A two-entry result queue decouples the sides, so the block keeps taking one
// byte per cycle while a result waits; text_stall rises only when both
// entries are full, and a result held by result_stall stays put.
// The config port (cfg_valid / cfg_ready / cfg_index / cfg_data) is always
// ready; write it only between texts. Reset clears the window, the position
// count, the queue and the registers (pattern length back to 1). The last
// byte of each text also clears the window and the position count.
`default_nettype none

module first_pattern_match_search #(
  parameter int unsigned PATTERN_MAX    = 16,
  parameter int unsigned POSITION_WIDTH = 32
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   text_valid,
  output logic                                  text_stall,
  input  wire  fpms_pkg::text_item_t            text_item,
  output logic                                  result_valid,
  input  wire                                   result_stall,
  output fpms_pkg::result_item_t                result_item,
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire  [fpms_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire  [fpms_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int unsigned LEN_W = $clog2(PATTERN_MAX + 1);
  localparam int unsigned LW    = (LEN_W > fpms_pkg::LENGTH_W) ? LEN_W : fpms_pkg::LENGTH_W;
  localparam int unsigned IW    = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int unsigned PW    = POSITION_WIDTH;
  localparam int unsigned XW    = (PW + 1 > fpms_pkg::OFFSET_W) ? PW + 1 : fpms_pkg::OFFSET_W;

  // configuration registers
  logic [fpms_pkg::CFG_DATA_W-1:0] pattern_low;
  logic [fpms_pkg::CFG_DATA_W-1:0] pattern_high;
  logic [fpms_pkg::LENGTH_W-1:0]   pattern_length;
  logic [fpms_pkg::OFFSET_W-1:0]   start_offset;

  // stream state
  logic [7:0]    byte_window      [PATTERN_MAX];
  logic [7:0]    byte_window_next [PATTERN_MAX];
  logic [PW-1:0] position_count;
  logic [PW-1:0] position_count_next;
  logic          search_done;

  // result queue
  logic [1:0]             count;
  fpms_pkg::result_item_t slot0;
  fpms_pkg::result_item_t slot1;
  fpms_pkg::result_item_t new_result;

  logic text_accept;
  logic result_pop;
  logic result_push;

  logic [2*fpms_pkg::CFG_DATA_W-1:0] pattern_bits;
  logic [7:0]             pat     [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] lane_ok;
  logic [LW-1:0]          len_raw;
  logic [LW-1:0]          len_eff;
  logic [PW:0]            cur_p1;
  logic [PW:0]            begin_val;
  logic [XW-1:0]          begin_x;
  logic                   len_fits;
  logic                   begin_ok;
  logic                   hit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= fpms_pkg::LENGTH_W'(1);
      start_offset   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (fpms_pkg::cfg_reg_t'(cfg_index))
        fpms_pkg::CFG_PATTERN_LOW:    pattern_low    <= cfg_data;
        fpms_pkg::CFG_PATTERN_HIGH:   pattern_high   <= cfg_data;
        fpms_pkg::CFG_PATTERN_LENGTH: pattern_length <= cfg_data[fpms_pkg::LENGTH_W-1:0];
        fpms_pkg::CFG_START_OFFSET:   start_offset   <= cfg_data[fpms_pkg::OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  assign pattern_bits = {pattern_high, pattern_low};

  // pattern bytes past the two registers read as zero
  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_pat
    if (j < fpms_pkg::PATTERN_REG_BYTES) begin : g_reg
      assign pat[j] = pattern_bits[8*j +: 8];
    end else begin : g_zero
      assign pat[j] = 8'd0;
    end
  end

  assign len_raw = LW'(pattern_length);
  assign len_eff = (len_raw > LW'(PATTERN_MAX)) ? LW'(PATTERN_MAX) : len_raw;

  assign byte_window_next[0] = text_item.text_byte;
  for (genvar k = 1; k < PATTERN_MAX; k++) begin : g_shift
    assign byte_window_next[k] = byte_window[k-1];
  end

  // lane k holds the byte at pattern index len-1-k; lanes past len are don't-care
  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_lane
    logic [LW-1:0] sel;
    assign sel        = len_eff - LW'(1) - LW'(k);
    assign lane_ok[k] = (LW'(k) >= len_eff) || (byte_window_next[k] == pat[sel[IW-1:0]]);
  end

  assign cur_p1    = {1'b0, position_count} + (PW+1)'(1);
  assign len_fits  = cur_p1 >= (PW+1)'(len_eff);
  assign begin_val = cur_p1 - (PW+1)'(len_eff);
  assign begin_x   = XW'(begin_val);
  assign begin_ok  = begin_x >= XW'(start_offset);
  assign hit       = !search_done && (len_eff != '0) && len_fits && begin_ok && (&lane_ok);

  assign position_count_next = (&position_count) ? position_count : cur_p1[PW-1:0];

  assign new_result.found          = hit;
  assign new_result.match_position = hit ? begin_x[fpms_pkg::MATCH_POS_W-1:0] : '0;

  assign text_stall   = (count == 2'd2);
  assign text_accept  = text_valid && !text_stall;
  assign result_valid = (count != 2'd0);
  assign result_pop   = result_valid && !result_stall;
  assign result_push  = text_accept && (hit || (text_item.last_byte && !search_done));
  assign result_item  = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      position_count <= '0;
      search_done    <= 1'b0;
      for (int i = 0; i < PATTERN_MAX; i++) begin
        byte_window[i] <= 8'd0;
      end
    end else if (text_accept) begin
      if (text_item.last_byte) begin
        position_count <= '0;
        search_done    <= 1'b0;
        for (int i = 0; i < PATTERN_MAX; i++) begin
          byte_window[i] <= 8'd0;
        end
      end else begin
        position_count <= position_count_next;
        search_done    <= search_done || hit;
        for (int i = 0; i < PATTERN_MAX; i++) begin
          byte_window[i] <= byte_window_next[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + {1'b0, result_push} - {1'b0, result_pop};
    end
  end

  // queue payload: head is slot0
  always_ff @(posedge clk) begin
    if (result_pop && result_push) begin
      if (count == 2'd1) begin
        slot0 <= new_result;
      end else begin
        slot0 <= slot1;
        slot1 <= new_result;
      end
    end else if (result_pop) begin
      slot0 <= slot1;
    end else if (result_push) begin
      if (count == 2'd0) begin
        slot0 <= new_result;
      end else begin
        slot1 <= new_result;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("result queue overflow");

  a_clear_on_last: assert property (@(posedge clk) disable iff (rst)
    text_accept && text_item.last_byte |=> position_count == '0 && !search_done)
    else $error("stream state not cleared after last byte");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    search_done && !(text_accept && text_item.last_byte) |=> search_done)
    else $error("search_done dropped mid-text");

  a_single_found: assert property (@(posedge clk) disable iff (rst)
    result_push |-> !search_done)
    else $error("second result for one text");

  a_found_sets_done: assert property (@(posedge clk) disable iff (rst)
    text_accept && hit && !text_item.last_byte |=> search_done)
    else $error("match did not mark search done");

endmodule

`default_nettype wire
